>>> src/frame_sequence_gap_filler_top_macros.svh
// Assertion macros used by the gap filler datapath
`ifndef FRAME_SEQUENCE_GAP_FILLER_TOP_MACROS_SVH
`define FRAME_SEQUENCE_GAP_FILLER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked at every rising edge out of reset
`define FSGF_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fsgf: same-cycle check failed");
// next-cycle implication
`define FSGF_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fsgf: next-cycle check failed");
`else
`define FSGF_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define FSGF_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

>>> src/fsgf_pkg.sv
// Types and constants of the frame sequence gap filler
package fsgf_pkg;

  localparam int TID_W = 10;
  localparam int DAY_W = 17;
  localparam int SEC_W = 17;
  localparam int IDX_W = 24;
  localparam int LEN_W = 24;
  localparam int FPS_W = 24;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [SEC_W:0] SECONDS_PER_DAY = (SEC_W + 1)'(86400);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THREAD_SELECT     = 1'b0,
    REG_FRAMES_PER_SECOND = 1'b1
  } fsgf_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FILL,
    ST_LERR
  } fsgf_state_t;

  // controller to datapath
  typedef struct packed {
    logic take_hdr;
    logic emit_fill;
    logic emit_real;
    logic emit_lerr;
  } fsgf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic halted;
    logic thread_match;
    logic length_match;
    logic stamp_match;
    logic cap_hit;
    logic slot_free;
  } fsgf_sts_t;

endpackage

>>> src/fsgf_if.sv
// Channel interfaces: header input, result output and configuration write
interface fsgf_hdr_if;
  logic                         valid;
  logic                         ready;
  logic [fsgf_pkg::TID_W-1:0]   thread_id;
  logic [fsgf_pkg::DAY_W-1:0]   frame_day;
  logic [fsgf_pkg::SEC_W-1:0]   frame_second;
  logic [fsgf_pkg::IDX_W-1:0]   frame_index;
  logic                         frame_bad;
  logic [fsgf_pkg::LEN_W-1:0]   frame_length;

  modport source (output valid, thread_id, frame_day, frame_second, frame_index,
                  frame_bad, frame_length, input ready);
  modport sink   (input valid, thread_id, frame_day, frame_second, frame_index,
                  frame_bad, frame_length, output ready);
endinterface

interface fsgf_res_if;
  logic                         valid;
  logic                         ready;
  logic [fsgf_pkg::DAY_W-1:0]   out_day;
  logic [fsgf_pkg::SEC_W-1:0]   out_second;
  logic [fsgf_pkg::IDX_W-1:0]   out_index;
  logic                         out_bad;
  logic                         is_filler;
  logic                         fill_overflow;
  logic                         length_error;
  logic                         last;

  modport source (output valid, out_day, out_second, out_index, out_bad, is_filler,
                  fill_overflow, length_error, last, input ready);
  modport sink   (input valid, out_day, out_second, out_index, out_bad, is_filler,
                  fill_overflow, length_error, last, output ready);
endinterface

interface fsgf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [fsgf_pkg::CFG_IDX_W-1:0]    index;
  logic [fsgf_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/fsgf_ctrl.sv
// Sequencer of the gap filler: header intake, evaluation, filler and result issue
module fsgf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                hdr_valid,
  output logic                hdr_ready,
  input  fsgf_pkg::fsgf_sts_t sts,
  output fsgf_pkg::fsgf_cmd_t cmd
);

  fsgf_pkg::fsgf_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fsgf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fsgf_pkg::ST_IDLE: begin
        if (hdr_valid) state_next = fsgf_pkg::ST_EVAL;
      end
      fsgf_pkg::ST_EVAL: begin
        if (sts.halted || !sts.thread_match) state_next = fsgf_pkg::ST_IDLE;
        else if (!sts.length_match)          state_next = fsgf_pkg::ST_LERR;
        else                                 state_next = fsgf_pkg::ST_FILL;
      end
      fsgf_pkg::ST_FILL: begin
        if (sts.slot_free && (sts.stamp_match || sts.cap_hit))
          state_next = fsgf_pkg::ST_IDLE;
      end
      fsgf_pkg::ST_LERR: begin
        if (sts.slot_free) state_next = fsgf_pkg::ST_IDLE;
      end
      default: state_next = fsgf_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    hdr_ready     = 1'b0;
    cmd           = '0;
    unique case (state)
      fsgf_pkg::ST_IDLE: begin
        hdr_ready    = 1'b1;
        cmd.take_hdr = hdr_valid;
      end
      fsgf_pkg::ST_EVAL: begin
      end
      fsgf_pkg::ST_FILL: begin
        cmd.emit_fill = sts.slot_free && !sts.stamp_match && !sts.cap_hit;
        cmd.emit_real = sts.slot_free && (sts.stamp_match || sts.cap_hit);
      end
      fsgf_pkg::ST_LERR: begin
        cmd.emit_lerr = sts.slot_free;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> src/fsgf_dpath.sv
// Datapath: registers, expected stamp, filler count and result register
`include "frame_sequence_gap_filler_top_macros.svh"

module fsgf_dpath #(
  parameter int MAX_FILL = 63
) (
  input  logic                clk,
  input  logic                rst,
  fsgf_cfg_if.sink            cfg,
  fsgf_hdr_if.sink            hdr,
  fsgf_res_if.source          res,
  input  fsgf_pkg::fsgf_cmd_t cmd,
  output fsgf_pkg::fsgf_sts_t sts
);

  localparam int CNT_W = $clog2(MAX_FILL + 1);

  // configuration
  logic [fsgf_pkg::TID_W-1:0] thread_select;
  logic [fsgf_pkg::FPS_W-1:0] frames_per_second;

  // captured header
  logic [fsgf_pkg::TID_W-1:0] h_tid;
  logic [fsgf_pkg::DAY_W-1:0] h_day;
  logic [fsgf_pkg::SEC_W-1:0] h_sec;
  logic [fsgf_pkg::IDX_W-1:0] h_idx;
  logic                       h_bad;
  logic [fsgf_pkg::LEN_W-1:0] h_len;

  // tracking state
  logic [fsgf_pkg::DAY_W-1:0] exp_day;
  logic [fsgf_pkg::SEC_W-1:0] exp_sec;
  logic [fsgf_pkg::IDX_W-1:0] exp_idx;
  logic [fsgf_pkg::LEN_W-1:0] ref_len;
  logic                       seeded;
  logic                       halted;
  logic [CNT_W-1:0]           count;

  // result register
  logic                       res_valid;
  logic [fsgf_pkg::DAY_W-1:0] r_day;
  logic [fsgf_pkg::SEC_W-1:0] r_sec;
  logic [fsgf_pkg::IDX_W-1:0] r_idx;
  logic                       r_bad;
  logic                       r_fill;
  logic                       r_ovf;
  logic                       r_lerr;
  logic                       r_last;

  // stamp advance
  logic [fsgf_pkg::DAY_W-1:0] base_day, adv_day;
  logic [fsgf_pkg::SEC_W-1:0] base_sec, adv_sec;
  logic [fsgf_pkg::IDX_W-1:0] base_idx, adv_idx;
  logic [fsgf_pkg::IDX_W:0]   idx_inc;
  logic [fsgf_pkg::SEC_W:0]   sec_inc;
  logic                       slot_free;
  logic                       any_emit;

  assign cfg.ready = 1'b1;

  // advance from the header stamp on the real result, else from the expected stamp
  always_comb begin
    base_day = cmd.emit_real ? h_day : exp_day;
    base_sec = cmd.emit_real ? h_sec : exp_sec;
    base_idx = cmd.emit_real ? h_idx : exp_idx;
    idx_inc  = {1'b0, base_idx} + (fsgf_pkg::IDX_W + 1)'(1);
    sec_inc  = {1'b0, base_sec} + (fsgf_pkg::SEC_W + 1)'(1);
    adv_day  = base_day;
    adv_sec  = base_sec;
    adv_idx  = idx_inc[fsgf_pkg::IDX_W-1:0];
    if (idx_inc >= {1'b0, frames_per_second}) begin
      adv_idx = '0;
      if (sec_inc >= fsgf_pkg::SECONDS_PER_DAY) begin
        adv_sec = '0;
        adv_day = base_day + fsgf_pkg::DAY_W'(1);
      end else begin
        adv_sec = sec_inc[fsgf_pkg::SEC_W-1:0];
      end
    end
  end

  // status to the sequencer
  assign slot_free = !res_valid || res.ready;
  assign any_emit  = cmd.emit_fill || cmd.emit_real || cmd.emit_lerr;

  always_comb begin
    sts.halted       = halted;
    sts.thread_match = (h_tid == thread_select);
    sts.length_match = (h_len == ref_len);
    sts.stamp_match  = (exp_day == h_day) && (exp_sec == h_sec) && (exp_idx == h_idx);
    sts.cap_hit      = (count == CNT_W'(MAX_FILL));
    sts.slot_free    = slot_free;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      thread_select     <= '0;
      frames_per_second <= fsgf_pkg::FPS_W'(1);
    end else if (cfg.valid) begin
      unique case (fsgf_pkg::fsgf_reg_t'(cfg.index))
        fsgf_pkg::REG_THREAD_SELECT:
          thread_select <= cfg.data[fsgf_pkg::TID_W-1:0];
        fsgf_pkg::REG_FRAMES_PER_SECOND:
          frames_per_second <= cfg.data[fsgf_pkg::FPS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // header capture
  always_ff @(posedge clk) begin
    if (cmd.take_hdr) begin
      h_tid <= hdr.thread_id;
      h_day <= hdr.frame_day;
      h_sec <= hdr.frame_second;
      h_idx <= hdr.frame_index;
      h_bad <= hdr.frame_bad;
      h_len <= hdr.frame_length;
    end
  end

  // control flags and filler count
  always_ff @(posedge clk) begin
    if (rst) begin
      seeded <= 1'b0;
      halted <= 1'b0;
      count  <= '0;
    end else begin
      if (cmd.take_hdr) begin
        count <= '0;
        if (!halted) seeded <= 1'b1;
      end
      if (cmd.emit_fill) count  <= count + CNT_W'(1);
      if (cmd.emit_lerr) halted <= 1'b1;
    end
  end

  // expected stamp and reference length; the first header seeds both
  always_ff @(posedge clk) begin
    if (cmd.take_hdr && !halted && !seeded) begin
      exp_day <= hdr.frame_day;
      exp_sec <= hdr.frame_second;
      exp_idx <= hdr.frame_index;
      ref_len <= hdr.frame_length;
    end else if (cmd.emit_fill || cmd.emit_real) begin
      exp_day <= adv_day;
      exp_sec <= adv_sec;
      exp_idx <= adv_idx;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (any_emit) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.emit_fill) begin
      r_day  <= exp_day;
      r_sec  <= exp_sec;
      r_idx  <= exp_idx;
      r_bad  <= 1'b1;
      r_fill <= 1'b1;
      r_ovf  <= 1'b0;
      r_lerr <= 1'b0;
      r_last <= 1'b0;
    end else if (cmd.emit_real) begin
      r_day  <= h_day;
      r_sec  <= h_sec;
      r_idx  <= h_idx;
      r_bad  <= h_bad;
      r_fill <= 1'b0;
      r_ovf  <= !sts.stamp_match;
      r_lerr <= 1'b0;
      r_last <= 1'b1;
    end else if (cmd.emit_lerr) begin
      r_day  <= '0;
      r_sec  <= '0;
      r_idx  <= '0;
      r_bad  <= 1'b0;
      r_fill <= 1'b0;
      r_ovf  <= 1'b0;
      r_lerr <= 1'b1;
      r_last <= 1'b1;
    end
  end

  assign res.valid         = res_valid;
  assign res.out_day       = r_day;
  assign res.out_second    = r_sec;
  assign res.out_index     = r_idx;
  assign res.out_bad       = r_bad;
  assign res.is_filler     = r_fill;
  assign res.fill_overflow = r_ovf;
  assign res.length_error  = r_lerr;
  assign res.last          = r_last;

  // checks
  `FSGF_ASSERT_IMPLY(a_one_emit, clk, rst, 1'b1,
    $onehot0({cmd.emit_fill, cmd.emit_real, cmd.emit_lerr}))
  `FSGF_ASSERT_IMPLY(a_emit_slot, clk, rst, any_emit, slot_free)
  `FSGF_ASSERT_IMPLY(a_count_cap, clk, rst, 1'b1, count <= CNT_W'(MAX_FILL))
  `FSGF_ASSERT_NEXT(a_lerr_halts, clk, rst, cmd.emit_lerr, halted)
  `FSGF_ASSERT_NEXT(a_halt_sticks, clk, rst, halted, halted && !any_emit)

endmodule

>>> src/frame_sequence_gap_filler_top.sv
// Top level of the frame sequence gap filler
//
//  channel  dir  transfer on          payload
//  cfg      in   cfg.valid&ready      index (register), data
//  hdr      in   hdr.valid&ready      frame header fields
//  res      out  res.valid&ready      emitted header, flags, last
//
// An accepted header passes through intake and evaluation, then one result is
// issued per cycle while the result register is free: up to MAX_FILL + 1
// results with a full filler run. Dropped headers pass through intake and
// evaluation only. A result stalled at the output holds the
// sequencer; the next header is taken while the last result still waits.
// Synchronous reset restores the configuration defaults; no clearing pass.
module frame_sequence_gap_filler_top #(
  parameter int MAX_FILL = 63
) (
  input  logic       clk,
  input  logic       rst,
  fsgf_cfg_if.sink   cfg,
  fsgf_hdr_if.sink   hdr,
  fsgf_res_if.source res
);

  fsgf_pkg::fsgf_cmd_t cmd;
  fsgf_pkg::fsgf_sts_t sts;
  logic                hdr_ready;

  assign hdr.ready = hdr_ready;

  // sequencer
  fsgf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .hdr_valid (hdr.valid),
    .hdr_ready (hdr_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  fsgf_dpath #(
    .MAX_FILL (MAX_FILL)
  ) u_dpath (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .hdr (hdr),
    .res (res),
    .cmd (cmd),
    .sts (sts)
  );

endmodule

>>> tb/sv/tb_frame_sequence_gap_filler_top.sv
// Testbench for the frame sequence gap filler: directed and random headers, scoreboard checks
`timescale 1ns / 1ps

module tb_frame_sequence_gap_filler_top;

  localparam int FILL_CAP       = 63;
  localparam int DRAIN_CYCLES   = 80;
  localparam int HOLD_CYCLES    = 400;
  localparam int KEPT_PER_PHASE = 65;

  typedef struct packed {
    logic [fsgf_pkg::DAY_W-1:0] day;
    logic [fsgf_pkg::SEC_W-1:0] sec;
    logic [fsgf_pkg::IDX_W-1:0] idx;
  } stamp_t;

  typedef struct packed {
    logic [fsgf_pkg::TID_W-1:0] tid;
    stamp_t                     stamp;
    logic                       bad;
    logic [fsgf_pkg::LEN_W-1:0] len;
  } header_t;

  typedef struct packed {
    stamp_t stamp;
    logic   bad;
    logic   filler;
    logic   ovf;
    logic   lerr;
    logic   last;
  } emitted_t;

  // Predicts the emitted header stream and checks it in order
  class gap_scoreboard;
    logic [fsgf_pkg::TID_W-1:0] sel_thread;
    int unsigned                fps;
    stamp_t                     next_due;
    bit                         seeded;
    logic [fsgf_pkg::LEN_W-1:0] ref_len;
    bit                         halted;
    emitted_t                   due[$];
    int                         errors;

    function new();
      sel_thread = '0;
      fps        = 1;
      next_due   = '0;
      seeded     = 1'b0;
      ref_len    = '0;
      halted     = 1'b0;
      errors     = 0;
    endfunction

    function void write_reg(fsgf_pkg::fsgf_reg_t r, logic [fsgf_pkg::CFG_DATA_W-1:0] d);
      case (r)
        fsgf_pkg::REG_THREAD_SELECT:     sel_thread = d[fsgf_pkg::TID_W-1:0];
        fsgf_pkg::REG_FRAMES_PER_SECOND: fps = 32'(d);
        default: ;
      endcase
    endfunction

    // one frame on: index wraps at the rate, second wraps at a day
    function stamp_t step_stamp(stamp_t s);
      stamp_t      n;
      int unsigned idx_up;
      int unsigned sec_up;
      n      = s;
      idx_up = 32'(s.idx) + 32'd1;
      sec_up = 32'(s.sec) + 32'd1;
      n.idx  = idx_up[fsgf_pkg::IDX_W-1:0];
      if (idx_up >= fps) begin
        n.idx = '0;
        if (sec_up >= 32'(fsgf_pkg::SECONDS_PER_DAY)) begin
          n.sec = '0;
          n.day = s.day + fsgf_pkg::DAY_W'(1);
        end else begin
          n.sec = sec_up[fsgf_pkg::SEC_W-1:0];
        end
      end
      return n;
    endfunction

    function void note_header(header_t h);
      int n;
      bit ovf;
      n = 0;
      if (halted) return;
      if (!seeded) begin
        next_due = h.stamp;
        ref_len  = h.len;
        seeded   = 1'b1;
      end
      if (h.tid != sel_thread) return;
      // length change: a lone error result, then nothing until reset
      if (h.len != ref_len) begin
        due.push_back(emitted_t'{stamp_t'(0), 1'b0, 1'b0, 1'b0, 1'b1, 1'b1});
        halted = 1'b1;
        return;
      end
      while (n < FILL_CAP && next_due != h.stamp) begin
        due.push_back(emitted_t'{next_due, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0});
        next_due = step_stamp(next_due);
        n++;
      end
      // past the cap the stamp resynchronises to the header
      ovf      = (next_due != h.stamp);
      next_due = h.stamp;
      due.push_back(emitted_t'{h.stamp, h.bad, 1'b0, ovf, 1'b0, 1'b1});
      next_due = step_stamp(next_due);
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(emitted_t got);
      emitted_t want;
      if (due.size() == 0) begin
        $display("%0t: unexpected result, none outstanding, actual %h", $time, got);
        errors++;
        return;
      end
      want = due.pop_front();
      compare("out_day", want.stamp.day, got.stamp.day);
      compare("out_second", want.stamp.sec, got.stamp.sec);
      compare("out_index", want.stamp.idx, got.stamp.idx);
      compare("out_bad", want.bad, got.bad);
      compare("is_filler", want.filler, got.filler);
      compare("fill_overflow", want.ovf, got.ovf);
      compare("length_error", want.lerr, got.lerr);
      compare("last", want.last, got.last);
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   hold_req;
  int   burst_left;

  gap_scoreboard sb = new();

  fsgf_cfg_if cfg_ch();
  fsgf_hdr_if hdr_ch();
  fsgf_res_if res_ch();

  frame_sequence_gap_filler_top #(
    .MAX_FILL(FILL_CAP)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .hdr(hdr_ch),
    .res(res_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // next header of the kept thread, a given number of frames ahead
  function automatic header_t follow_on(int unsigned gap);
    header_t h;
    stamp_t  s;
    s = sb.next_due;
    repeat (gap) s = sb.step_stamp(s);
    h.tid   = sb.sel_thread;
    h.stamp = s;
    h.bad   = 1'($urandom_range(0, 1));
    h.len   = sb.ref_len;
    return h;
  endfunction

  // mostly well-formed sequences, some jumps, wrap edges and foreign threads
  function automatic header_t random_header();
    header_t     h;
    int unsigned pick;
    int unsigned top;
    pick = $urandom_range(0, 99);
    top  = sb.fps - 1;
    if (pick < 62) begin
      h = follow_on(0);
    end else if (pick < 75) begin
      h = follow_on($urandom_range(1, 5));
    end else if (pick < 81) begin
      h = follow_on($urandom_range(FILL_CAP - 2, FILL_CAP + 2));
    end else begin
      h.tid       = sb.sel_thread;
      h.bad       = 1'($urandom_range(0, 1));
      h.len       = sb.ref_len;
      h.stamp.day = fsgf_pkg::DAY_W'($urandom);
      h.stamp.sec = fsgf_pkg::SEC_W'($urandom_range(0, 86399));
      h.stamp.idx = ($urandom_range(0, 3) == 0) ? fsgf_pkg::IDX_W'($urandom)
                                                : fsgf_pkg::IDX_W'($urandom_range(0, top));
      if (pick >= 87 && pick < 92) begin
        // just short of a second or day boundary
        h.stamp.sec = fsgf_pkg::SEC_W'(86399);
        h.stamp.idx = fsgf_pkg::IDX_W'(top - $urandom_range(0, (top < 3) ? top : 3));
        if ($urandom_range(0, 1) == 1) h.stamp.day = '1;
      end else if (pick >= 92) begin
        h.tid = sb.sel_thread ^ fsgf_pkg::TID_W'($urandom_range(1, 1023));
        h.len = fsgf_pkg::LEN_W'($urandom);
      end
    end
    return h;
  endfunction

  // offer one header in bursts with random gaps; returns on its transfer
  task automatic send(header_t h);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        hdr_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    hdr_ch.valid        <= 1'b1;
    hdr_ch.thread_id    <= h.tid;
    hdr_ch.frame_day    <= h.stamp.day;
    hdr_ch.frame_second <= h.stamp.sec;
    hdr_ch.frame_index  <= h.stamp.idx;
    hdr_ch.frame_bad    <= h.bad;
    hdr_ch.frame_length <= h.len;
    burst_left--;
    do @(posedge clk); while (!hdr_ch.ready);
    sb.note_header(h);
  endtask

  // stop offering and wait until every result is out and the block is quiet
  task automatic drain();
    hdr_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [fsgf_pkg::TID_W-1:0] thread,
                           logic [fsgf_pkg::CFG_DATA_W-1:0] rate);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= fsgf_pkg::REG_THREAD_SELECT;
    cfg_ch.data  <= fsgf_pkg::CFG_DATA_W'(thread);
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(fsgf_pkg::REG_THREAD_SELECT, fsgf_pkg::CFG_DATA_W'(thread));
    cfg_ch.index <= fsgf_pkg::REG_FRAMES_PER_SECOND;
    cfg_ch.data  <= rate;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(fsgf_pkg::REG_FRAMES_PER_SECOND, rate);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_random();
    int      kept;
    header_t h;
    kept = 0;
    while (kept < KEPT_PER_PHASE) begin
      h = random_header();
      send(h);
      if (h.tid == sb.sel_thread) kept++;
    end
  endtask

  // result side: stall pattern of its own plus one long hold-off on request
  initial begin
    int hold_left;
    int mode;
    int mode_left;
    hold_left    = 0;
    mode         = 0;
    mode_left    = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(5, 60);
        end
        mode_left--;
        case (mode)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= 1'($urandom_range(0, 1));
          default: res_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // result transfers go straight to the scoreboard
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      sb.check_result({res_ch.out_day, res_ch.out_second, res_ch.out_index, res_ch.out_bad,
                       res_ch.is_filler, res_ch.fill_overflow, res_ch.length_error,
                       res_ch.last});
    end
  end

  // run limit
  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [fsgf_pkg::LEN_W-1:0] len_seed;
    header_t                    h;
    rst                 = 1'b1;
    hold_req            = 1'b0;
    burst_left          = 0;
    hdr_ch.valid        = 1'b0;
    hdr_ch.thread_id    = '0;
    hdr_ch.frame_day    = '0;
    hdr_ch.frame_second = '0;
    hdr_ch.frame_index  = '0;
    hdr_ch.frame_bad    = 1'b0;
    hdr_ch.frame_length = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = fsgf_pkg::REG_THREAD_SELECT;
    cfg_ch.data         = '0;
    len_seed            = fsgf_pkg::LEN_W'($urandom);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // short rate, kept thread 5
    configure(10'd5, 24'd3);
    // foreign thread still seeds the stamp and length
    send(header_t'{10'd7, stamp_t'{17'h1FFFF, 17'd86399, 24'd1}, 1'b0, len_seed});
    send(header_t'{10'd5, stamp_t'{17'h1FFFF, 17'd86399, 24'd1}, 1'b1, len_seed});
    // fillers across the day wrap
    send(follow_on(2));
    send(follow_on(FILL_CAP));
    send(follow_on(FILL_CAP + 1));
    send(follow_on(FILL_CAP - 1));
    // foreign threads with extreme fields are dropped
    send(header_t'{10'h3FF, stamp_t'{17'h1FFFF, 17'd86399, 24'hFFFFFF}, 1'b1, 24'hFFFFFF});
    send(header_t'{10'd0, stamp_t'(0), 1'b0, 24'd0});
    // index beyond the rate is never reached by counting
    send(header_t'{10'd5, stamp_t'{17'd0, 17'd0, 24'hFFFFFF}, 1'b0, len_seed});
    send(follow_on(0));
    send(header_t'{10'd5, stamp_t'(0), 1'b1, len_seed});
    send(follow_on(0));
    run_random();

    // widest thread and rate
    configure(10'h3FF, 24'hFFFFFF);
    send(header_t'{10'h3FF, stamp_t'{17'd0, 17'd86399, 24'hFFFFFD}, 1'b0, len_seed});
    send(follow_on(1));
    send(follow_on(0));
    run_random();

    // one frame per second, with a long output hold-off
    configure(10'd0, 24'd1);
    hold_req = 1'b1;
    run_random();

    configure(fsgf_pkg::TID_W'($urandom_range(1, 1022)),
              fsgf_pkg::CFG_DATA_W'($urandom_range(2, 1000)));
    run_random();

    // length change halts the block; later headers give nothing
    h     = follow_on(0);
    h.len = ~len_seed;
    send(h);
    send(follow_on(0));
    send(random_header());
    send(random_header());

    drain();
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
